/* src/hwpr_pkg.sv */
`timescale 1ns / 1ps
package hwpr_pkg;

	// iterative unit widths
	localparam int SQ_W  = 50;
	localparam int DIV_W = 40;
	localparam int DEN_W = 25;
	localparam int CNT_W = 6;

	typedef logic signed [17:0] col_t;

	// light direction, Q.15
	localparam col_t LX = -18'sd14727;
	localparam col_t LY = 18'sd26182;
	localparam col_t LZ = -18'sd13091;

	localparam col_t LIGHT_K   = 18'sd22938;
	localparam col_t AMBIENT   = 18'sd8192;
	localparam col_t ONE_Q15   = 18'sd32768;
	localparam col_t PIN_F     = 18'sd18022;
	localparam logic [15:0] NY_K = 16'd19661;

	// (depth << 30) / 1536 == (depth << 21) / 3: reciprocal of 3 in Q.17,
	// plus floor(r * 2^21 / 3) for the remainder r
	localparam logic [31:0] WET_RECIP = 32'd43691;
	localparam logic [SQ_W-1:0] WET_FRAC1 = 50'd699050;
	localparam logic [SQ_W-1:0] WET_FRAC2 = 50'd1398101;

	localparam col_t DRY_K [3] = '{18'sd20316, 18'sd19661, 18'sd18022};
	localparam col_t WET_A [3] = '{18'sd4915, 18'sd19661, 18'sd31130};
	localparam col_t WET_B [3] = '{18'sd655, 18'sd5898, 18'sd16384};
	localparam col_t PIN_C [3] = '{18'sd32768, 18'sd3277, 18'sd29491};

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_L, ST_RD_R, ST_RD_U, ST_RD_D, ST_WR, ST_SQ, ST_SUM, ST_CHK,
		ST_SQRT, ST_DIV, ST_LIGHT, ST_CLAMP, ST_DRY, ST_DRY_SH, ST_WDIV, ST_WSQRT,
		ST_WMUL, ST_WADD, ST_PMUL, ST_PADD, ST_BYTE, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		REG_GRID_SIDE, REG_TEXEL_SIZE, REG_DRY_THRESHOLD, REG_PIN_THRESHOLD
	} reg_index_t;

	// signed divide by 32768, truncating toward zero
	function automatic logic signed [20:0] trunc15(input logic signed [35:0] p);
		logic [35:0] m;
		logic [20:0] t;
		m = p[35] ? 36'(-p) : 36'(p);
		t = m[35:15];
		trunc15 = p[35] ? -$signed(t) : $signed(t);
	endfunction

endpackage

/* src/hwpr_isqrt.sv */
`timescale 1ns / 1ps
module hwpr_isqrt
	import hwpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_W-1:0]     operand,
	output logic                done,
	output logic [SQ_W/2-1:0]   root
);

	logic [SQ_W-1:0] v_q, r_q, bit_q;
	logic            busy_q, done_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[SQ_W/2-1:0];

endmodule

/* src/hwpr_div.sv */
`timescale 1ns / 1ps
module hwpr_div
	import hwpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DEN_W-1:0]  divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	logic [DEN_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   sh;

	assign sh = {rem_q[DEN_W-1:0], quo_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
			cnt_q <= CNT_W'(DIV_W - 1);
		end else if (busy_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= sh - {1'b0, den_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/hillshade_water_pixel_render.sv */
`timescale 1ns / 1ps
// Sequence: a pixel item reads its neighbours, then the slope normal goes through the square root
// and divider (skipped when the slope vector is all zero), then light, dry colour, the wet tint
// (a second square root) and the pin tint; the bit-serial square root (25 steps) and divider
// (40 steps) set most of it. Items are taken one at a time; one that gives no result is only written.
// The next item is taken while a finished pixel waits in the output register.
// Reset: asynchronous, active low; clears counters, registers to defaults, no pixel pending.
// Line buffer contents are undefined until written and need no clearing pass.
module hillshade_water_pixel_render
	import hwpr_pkg::*;
#(
	parameter int MAX_SIDE = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               op,
	input  logic signed [23:0] height,
	input  logic [15:0]        water_depth,
	input  logic signed [23:0] pinned_level,
	output logic               pixel_valid,
	input  logic               pixel_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               last_of_frame,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int CW = $clog2(MAX_SIDE + 1);
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	// configuration
	logic [10:0]        grid_side_q;
	logic [15:0]        texel_q, dry_q;
	logic signed [23:0] pin_thr_q;

	// frame position
	logic [CW-1:0] in_row_q, in_col_q, drain_col_q;
	logic [31:0]   side_w;
	logic [CW-1:0] side_n;

	state_t state_q, state_d;

	// line buffers
	logic signed [23:0] hmem [2**(AW+1)];
	logic [15:0]        dmem [2**AW];
	logic               pmem [2**AW];
	logic signed [23:0] hrd_q;
	logic [15:0]        drd_q;
	logic               prd_q;
	logic [AW:0]        hra;
	logic               mem_we, side_rd;

	// latched item
	logic               op_q, emit_q, last_q, pin_in_q;
	logic signed [23:0] h_q;
	logic [15:0]        dep_in_q;
	logic [AW:0]        al_q, ar_q, au_q, ad_q, wa_q;
	logic [AW-1:0]      col_q;

	// datapath
	logic signed [23:0] hl_q, hr_q, hu_q;
	logic [15:0]        dep_q;
	logic               pin_q;
	logic [15:0]        ny_q;
	logic signed [24:0] gx_q, gz_q;
	logic [49:0]        gx2_q, gz2_q;
	logic [31:0]        ny2_q;
	logic signed [41:0] px_q, py_q, pz_q, num_q;
	logic [49:0]        s_q;
	logic signed [19:0] dot_q;
	logic signed [35:0] lp_q;
	logic [16:0]        light_q;
	logic [15:0]        t_q;
	logic signed [35:0] cp_q [3];
	col_t               col_q3 [3];
	logic [22:0]        bp_q [3];
	logic signed [20:0] light_w;
	logic [41:0]        num_mag;

	// wet depth scaling
	logic [31:0]        wq_prod;
	logic [14:0]        wq_quo;
	logic [1:0]         wq_rem;
	logic [SQ_W-1:0]    wet_quo;

	// output register
	logic       pix_valid_q, pix_last_q;
	logic [7:0] pix_r_q, pix_g_q, pix_b_q;
	logic       out_load;

	// iterative units
	logic               sq_start, sq_done, dv_start, dv_done;
	logic [SQ_W-1:0]    sq_op;
	logic [SQ_W/2-1:0]  sq_root;
	logic [DIV_W-1:0]   dv_num, dv_quo;
	logic [DEN_W-1:0]   dv_den;

	logic accept, cfg_we, wet;

	assign side_w = (32'(grid_side_q) < 32'd2) ? 32'd2 :
		(32'(grid_side_q) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(grid_side_q);
	assign side_n = side_w[CW-1:0];

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign wet        = dep_q > dry_q;
	assign out_load   = (state_q == ST_OUT) && (!pix_valid_q || !pixel_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= 11'd1024;
			texel_q     <= 16'd256;
			dry_q       <= 16'd3;
			pin_thr_q   <= 24'sd256;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_GRID_SIDE:     grid_side_q <= cfg_data[10:0];
				REG_TEXEL_SIZE:    texel_q     <= cfg_data[15:0];
				REG_DRY_THRESHOLD: dry_q       <= cfg_data[15:0];
				REG_PIN_THRESHOLD: pin_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// item decode: counters advance at the transfer
	logic          a_drain_ok, a_data_ok, a_emit;
	logic [CW-1:0] a_c, a_p, a_cl, a_cr;
	logic          a_cur, a_up;

	always_comb begin
		a_drain_ok = (in_row_q == side_n);
		a_data_ok  = (in_row_q < side_n);
		a_c        = op ? drain_col_q : in_col_q;
		a_p        = op ? side_n - 1'b1 : in_row_q - 1'b1;
		a_emit     = op ? a_drain_ok : (a_data_ok && in_row_q != '0);
		a_cur      = a_p[0];
		a_up       = (a_p == '0) ? a_cur : ~a_cur;
		a_cl       = (a_c == '0) ? a_c : a_c - 1'b1;
		a_cr       = (a_c + 1'b1 >= side_n) ? side_n - 1'b1 : a_c + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			drain_col_q <= '0;
		end else if (cfg_we && reg_index_t'(cfg_index) == REG_GRID_SIDE) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			drain_col_q <= '0;
		end else if (accept) begin
			if (op) begin
				if (a_drain_ok) begin
					if (drain_col_q == side_n - 1'b1) begin
						in_row_q    <= '0;
						in_col_q    <= '0;
						drain_col_q <= '0;
					end else begin
						drain_col_q <= drain_col_q + 1'b1;
					end
				end
			end else if (a_data_ok) begin
				if (in_col_q + 1'b1 >= side_n) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			emit_q   <= a_emit;
			last_q   <= op && (drain_col_q == side_n - 1'b1);
			h_q      <= height;
			dep_in_q <= water_depth;
			pin_in_q <= pinned_level > pin_thr_q;
			col_q    <= a_c[AW-1:0];
			al_q     <= {a_cur, a_cl[AW-1:0]};
			ar_q     <= {a_cur, a_cr[AW-1:0]};
			au_q     <= {a_up, a_c[AW-1:0]};
			ad_q     <= {a_cur, a_c[AW-1:0]};
			wa_q     <= {in_row_q[0], a_c[AW-1:0]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (a_emit) state_d = ST_RD_L;
					else if (!op && a_data_ok) state_d = ST_WR;
				end
			end
			ST_RD_L:   state_d = ST_RD_R;
			ST_RD_R:   state_d = ST_RD_U;
			ST_RD_U:   state_d = ST_RD_D;
			ST_RD_D:   state_d = ST_WR;
			ST_WR:     state_d = emit_q ? ST_SQ : ST_IDLE;
			ST_SQ:     state_d = ST_SUM;
			ST_SUM:    state_d = ST_CHK;
			ST_CHK:    state_d = (s_q == '0) ? ST_LIGHT : ST_SQRT;
			ST_SQRT:   if (sq_done) state_d = ST_DIV;
			ST_DIV:    if (dv_done) state_d = ST_LIGHT;
			ST_LIGHT:  state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_DRY;
			ST_DRY:    state_d = ST_DRY_SH;
			ST_DRY_SH: state_d = wet ? ST_WDIV : (pin_q ? ST_PMUL : ST_BYTE);
			ST_WDIV:   state_d = ST_WSQRT;
			ST_WSQRT:  if (sq_done) state_d = ST_WMUL;
			ST_WMUL:   state_d = ST_WADD;
			ST_WADD:   state_d = pin_q ? ST_PMUL : ST_BYTE;
			ST_PMUL:   state_d = ST_PADD;
			ST_PADD:   state_d = ST_BYTE;
			ST_BYTE:   state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// depth / 6 m in Q.30, by reciprocal multiply
	assign wq_prod = 32'(dep_q) * WET_RECIP;
	assign wq_quo  = wq_prod[31:17];
	assign wq_rem  = 2'(dep_q - 16'(wq_quo) * 16'd3);
	assign wet_quo = SQ_W'({wq_quo, 21'b0}) +
		((wq_rem == 2'd2) ? WET_FRAC2 : (wq_rem == 2'd1) ? WET_FRAC1 : '0);

	// control outputs
	always_comb begin
		hra      = al_q;
		mem_we   = 1'b0;
		side_rd  = 1'b0;
		sq_start = 1'b0;
		dv_start = 1'b0;
		sq_op    = s_q;
		dv_num   = num_mag[DIV_W-1:0];
		dv_den   = sq_root;
		case (state_q)
			ST_RD_L: begin
				hra     = al_q;
				side_rd = 1'b1;
			end
			ST_RD_R: hra = ar_q;
			ST_RD_U: hra = au_q;
			ST_RD_D: hra = ad_q;
			ST_WR:   mem_we = !op_q;
			ST_CHK:  sq_start = (s_q != '0);
			ST_SQRT: dv_start = sq_done;
			ST_WDIV: begin
				sq_start = 1'b1;
				sq_op    = wet_quo;
			end
			default: ;
		endcase
	end

	assign num_mag = num_q[41] ? 42'(-num_q) : 42'(num_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hmem[wa_q]  <= h_q;
			dmem[col_q] <= dep_in_q;
			pmem[col_q] <= pin_in_q;
		end
		hrd_q <= hmem[hra];
		if (side_rd) begin
			drd_q <= dmem[col_q];
			prd_q <= pmem[col_q];
		end
	end

	hwpr_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_op),
		.done    (sq_done),
		.root    (sq_root)
	);

	hwpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_num),
		.divisor  (dv_den),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	assign light_w = 21'(AMBIENT) + trunc15(lp_q);

	// shading datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD_L: ny_q <= 16'((32'(texel_q) * 32'(NY_K) + 32'd16384) >> 15);
			ST_RD_R: begin
				hl_q  <= hrd_q;
				dep_q <= drd_q;
				pin_q <= prd_q;
			end
			ST_RD_U: hr_q <= hrd_q;
			ST_RD_D: hu_q <= hrd_q;
			ST_WR: begin
				gx_q <= 25'(hl_q) - 25'(hr_q);
				gz_q <= 25'(hu_q) - (op_q ? 25'(hrd_q) : 25'(h_q));
			end
			ST_SQ: begin
				gx2_q <= 50'(50'(gx_q) * 50'(gx_q));
				gz2_q <= 50'(50'(gz_q) * 50'(gz_q));
				ny2_q <= 32'(ny_q) * 32'(ny_q);
				px_q  <= 42'(gx_q) * 42'(LX);
				py_q  <= 42'($signed({1'b0, ny_q})) * 42'(LY);
				pz_q  <= 42'(gz_q) * 42'(LZ);
			end
			ST_SUM: begin
				s_q   <= gx2_q + gz2_q + 50'(ny2_q);
				num_q <= px_q + py_q + pz_q;
			end
			ST_CHK: dot_q <= 20'(LY);
			ST_DIV: begin
				if (dv_done) dot_q <= num_q[41] ? -$signed(dv_quo[19:0]) : $signed(dv_quo[19:0]);
			end
			ST_LIGHT: lp_q <= 36'(dot_q) * 36'(LIGHT_K);
			ST_CLAMP: begin
				if (light_w < 0)                 light_q <= '0;
				else if (light_w > 21'(ONE_Q15)) light_q <= 17'd32768;
				else                             light_q <= light_w[16:0];
			end
			ST_DRY: begin
				for (int i = 0; i < 3; i++)
					cp_q[i] <= 36'($signed({1'b0, light_q})) * 36'(DRY_K[i]);
			end
			ST_DRY_SH: begin
				for (int i = 0; i < 3; i++) col_q3[i] <= 18'(cp_q[i] >>> 15);
			end
			ST_WSQRT: begin
				if (sq_done) t_q <= (sq_root > 25'd32768) ? 16'd32768 : sq_root[15:0];
			end
			ST_WMUL: begin
				for (int i = 0; i < 3; i++)
					cp_q[i] <= (36'(WET_B[i]) - 36'(WET_A[i])) * 36'($signed({2'b0, t_q}));
			end
			ST_WADD: begin
				for (int i = 0; i < 3; i++) col_q3[i] <= 18'(21'(WET_A[i]) + trunc15(cp_q[i]));
			end
			ST_PMUL: begin
				for (int i = 0; i < 3; i++)
					cp_q[i] <= (36'(PIN_C[i]) - 36'(col_q3[i])) * 36'(PIN_F);
			end
			ST_PADD: begin
				for (int i = 0; i < 3; i++) col_q3[i] <= 18'(21'(col_q3[i]) + trunc15(cp_q[i]));
			end
			ST_BYTE: begin
				for (int i = 0; i < 3; i++) begin
					if (col_q3[i] < 0)            bp_q[i] <= '0;
					else if (col_q3[i] > ONE_Q15) bp_q[i] <= 23'(32768 * 255);
					else bp_q[i] <= 23'(col_q3[i][16:0]) * 23'd255;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_load) begin
			pix_valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_r_q    <= bp_q[0][22:15];
			pix_g_q    <= bp_q[1][22:15];
			pix_b_q    <= bp_q[2][22:15];
			pix_last_q <= last_q;
		end
	end

	assign pixel_valid   = pix_valid_q;
	assign red           = pix_r_q;
	assign green         = pix_g_q;
	assign blue          = pix_b_q;
	assign last_of_frame = pix_last_q;

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && $past(state_q) == ST_IDLE) |-> $past(item_valid && !item_stall))
		else $error("work started without an item transfer");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_col_q < side_n) && (drain_col_q < side_n) && (in_row_q <= side_n))
		else $error("frame position out of range");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid_q) |-> $past(state_q == ST_OUT))
		else $error("pixel presented outside output state");

endmodule

/* dv/hillshade_water_pixel_render_tb.sv */
`timescale 1ns / 1ps
module hillshade_water_pixel_render_tb;
	import hwpr_pkg::*;

	typedef struct {
		logic               op;
		logic signed [23:0] height;
		logic [15:0]        depth;
		logic signed [23:0] pinned;
	} cell_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} rgb_t;

	localparam int SIDE_CAP = 1024;
	localparam int WATCHDOG = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = 1'b0;
	logic signed [23:0] height = '0;
	logic [15:0] water_depth = '0;
	logic signed [23:0] pinned_level = '0;
	logic pixel_valid;
	logic pixel_stall = 1'b0;
	logic [7:0] red, green, blue;
	logic last_of_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_index_t cfg_index = REG_GRID_SIDE;
	logic [23:0] cfg_data = '0;

	hillshade_water_pixel_render DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cell_t cell_q[$];
	rgb_t pixel_q[$];
	int errors = 0;
	int send_gap_max = 4;
	int stall_max = 4;
	logic long_hold = 1'b0;
	int pushed = 0;

	// shading model state
	longint hgt_buf[2*SIDE_CAP];
	int unsigned dep_buf[SIDE_CAP];
	bit pin_buf[SIDE_CAP];
	int unsigned m_row, m_col, m_dcol;
	int unsigned m_side = 1024, m_texel = 256, m_dry = 3;
	longint m_pin = 256;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint mix(input longint a, input longint b, input longint f);
		return a + ((b - a) * f) / 32768;
	endfunction

	function automatic logic [7:0] to_byte(input longint v);
		longint c;
		c = v < 0 ? 0 : (v > 32768 ? 32768 : v);
		return 8'((c * 255) >> 15);
	endfunction

	function automatic rgb_t shade_cell(input int unsigned p, input int unsigned c,
			input int unsigned n, input longint hd);
		int unsigned cur, upb, cl, cr;
		longint gx, gz, ny, dotp, light, r, g, b, t;
		longint unsigned s;
		rgb_t px;
		cur = (p & 1) * SIDE_CAP;
		upb = p == 0 ? cur : ((p - 1) & 1) * SIDE_CAP;
		cl = c == 0 ? 0 : c - 1;
		cr = c + 1 >= n ? n - 1 : c + 1;
		gx = hgt_buf[cur + cl] - hgt_buf[cur + cr];
		gz = hgt_buf[upb + c] - hd;
		ny = (longint'(m_texel) * 19661 + 16384) >>> 15;
		s = gx * gx + ny * ny + gz * gz;
		if (s == 0)
			dotp = 26182;
		else
			dotp = (gx * (-14727) + ny * 26182 + gz * (-13091)) / longint'(isqrt(s));
		light = 8192 + (22938 * dotp) / 32768;
		if (light < 0) light = 0;
		if (light > 32768) light = 32768;
		r = (light * 20316) / 32768;
		g = (light * 19661) / 32768;
		b = (light * 18022) / 32768;
		if (dep_buf[c] > m_dry) begin
			t = longint'(isqrt((longint'(dep_buf[c]) << 30) / 1536));
			if (t > 32768) t = 32768;
			r = mix(4915, 655, t);
			g = mix(19661, 5898, t);
			b = mix(31130, 16384, t);
		end
		if (pin_buf[c]) begin
			r = mix(r, 32768, 18022);
			g = mix(g, 3277, 18022);
			b = mix(b, 29491, 18022);
		end
		px.r = to_byte(r);
		px.g = to_byte(g);
		px.b = to_byte(b);
		px.last = 1'b0;
		return px;
	endfunction

	task automatic shade_predict(input cell_t it);
		int unsigned n;
		rgb_t px;
		n = m_side < 2 ? 2 : (m_side > SIDE_CAP ? SIDE_CAP : m_side);
		if (m_row > n || m_col >= n || m_dcol >= n) begin
			m_row = 0; m_col = 0; m_dcol = 0;
		end
		if (it.op) begin
			if (m_row != n) return;
			px = shade_cell(n - 1, m_dcol, n, hgt_buf[((n - 1) & 1) * SIDE_CAP + m_dcol]);
			if (m_dcol == n - 1) begin
				px.last = 1'b1;
				m_row = 0; m_col = 0; m_dcol = 0;
			end else
				m_dcol++;
			pixel_q.push_back(px);
		end else begin
			if (m_row >= n) return;
			if (m_row > 0)
				pixel_q.push_back(shade_cell(m_row - 1, m_col, n, longint'(it.height)));
			hgt_buf[(m_row & 1) * SIDE_CAP + m_col] = longint'(it.height);
			dep_buf[m_col] = it.depth;
			pin_buf[m_col] = longint'(it.pinned) > m_pin;
			m_col++;
			if (m_col >= n) begin
				m_col = 0;
				m_row++;
			end
		end
	endtask

	// sender
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				shade_predict(cell_t'{op, height, water_depth, pinned_level});
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (cell_q.size() > 0) begin
					cell_t it;
					it = cell_q.pop_front();
					op <= it.op;
					height <= it.height;
					water_depth <= it.depth;
					pinned_level <= it.pinned;
					item_valid <= 1'b1;
					send_gap = $urandom_range(0, send_gap_max);
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				if (pixel_q.size() == 0)
					report("unexpected pixel", red, -1);
				else begin
					rgb_t w;
					w = pixel_q.pop_front();
					if (red != w.r) report("red", red, w.r);
					if (green != w.g) report("green", green, w.g);
					if (blue != w.b) report("blue", blue, w.b);
					if (last_of_frame != w.last) report("last_of_frame", last_of_frame, w.last);
				end
				stall_left = $urandom_range(0, stall_max);
			end else if (stall_left > 0)
				stall_left--;
			pixel_stall <= long_hold || stall_left != 0;
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (pixel_valid && !pixel_stall) ||
				(cell_q.size() == 0 && pixel_q.size() == 0 && !item_valid))
			quiet = 0;
		else if (++quiet >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push(input logic o, input logic signed [23:0] h, input logic [15:0] d,
			input logic signed [23:0] p);
		cell_q.push_back(cell_t'{o, h, d, p});
		pushed++;
	endtask

	task automatic settle();
		while (cell_q.size() > 0 || pixel_q.size() > 0 || item_valid) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRID_SIDE: begin
				m_side = val[10:0];
				m_row = 0; m_col = 0; m_dcol = 0;
			end
			REG_TEXEL_SIZE: m_texel = val[15:0];
			REG_DRY_THRESHOLD: m_dry = val[15:0];
			REG_PIN_THRESHOLD: m_pin = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic configure(input int side, input int texel, input int dry, input int pin);
		write_reg(REG_GRID_SIDE, 24'(side));
		write_reg(REG_TEXEL_SIZE, 24'(texel));
		write_reg(REG_DRY_THRESHOLD, 24'(dry));
		write_reg(REG_PIN_THRESHOLD, 24'(pin));
	endtask

	// one frame; rows beyond keep_rows are dropped to leave a broken frame
	task automatic push_frame(input int n, input int keep_rows, input bit noisy);
		int mode;
		logic signed [23:0] base, h;
		logic [15:0] d;
		mode = $urandom_range(0, 3);
		base = 24'($urandom);
		for (int r = 0; r < keep_rows; r++)
			for (int c = 0; c < n; c++) begin
				if (noisy && $urandom_range(0, 9) == 0)
					push(1'b1, 24'($urandom), 16'($urandom), 24'($urandom));
				case (mode)
					0: h = 24'($urandom);
					1: h = base + 24'($urandom_range(0, 8191)) - 24'sd4096;
					default: h = base + 24'($urandom_range(0, 255)) - 24'sd128;
				endcase
				case ($urandom_range(0, 4))
					0: d = 16'($urandom_range(0, 8));
					1: d = 16'(m_dry + $urandom_range(0, 2) - 1);
					2: d = 16'hFFFF;
					default: d = 16'($urandom);
				endcase
				push(1'b0, h, d, $urandom_range(0, 1) ? 24'(m_pin + 1) : 24'($urandom));
			end
		if (keep_rows < n) return;
		if (noisy && $urandom_range(0, 2) == 0)
			push(1'b0, 24'($urandom), 16'($urandom), 24'($urandom));
		for (int c = 0; c < n; c++) push(1'b1, 24'($urandom), 16'($urandom), 24'($urandom));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// side below range, zero texel gives a flat zero vector, wet extremes, pin floor
		configure(0, 0, 0, -8388608);
		push(1'b1, '0, '0, '0);
		push(1'b0, '0, 16'd0, 24'sh7FFFFF);
		push(1'b0, '0, 16'hFFFF, -24'sd8388608);
		push(1'b1, '0, '0, '0);
		push(1'b0, '0, 16'd1, 24'sd0);
		push(1'b0, '0, 16'h8000, 24'sd1);
		push(1'b0, 24'sh7FFFFF, '0, '0);
		push(1'b1, '0, '0, '0);
		push(1'b1, '0, '0, '0);
		settle();

		// height extremes, largest texel, pin ceiling
		configure(1, 65535, 65535, 8388607);
		push(1'b0, 24'sh7FFFFF, 16'hFFFF, 24'sh7FFFFF);
		push(1'b0, -24'sd8388608, 16'hFFFE, -24'sd8388608);
		push(1'b0, -24'sd8388608, 16'h0000, 24'sh7FFFFF);
		push(1'b0, 24'sh7FFFFF, 16'hFFFF, 24'sd0);
		push(1'b1, '0, '0, '0);
		push(1'b1, '0, '0, '0);
		settle();

		// side above range: a few first-row cells only, then restart
		configure(2047, 1, 3, 256);
		for (int i = 0; i < 5; i++) push(1'b0, 24'($urandom), 16'($urandom), 24'($urandom));
		settle();

		// receiver holds off while the sender keeps offering
		configure(8, 256, 3, 0);
		send_gap_max = 0;
		stall_max = 0;
		push_frame(8, 8, 1'b0);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
		settle();

		while (pushed < 600) begin
			int n, frames;
			n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 10) : $urandom_range(2, 6);
			configure(n, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 1024),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048) - 1024);
			send_gap_max = $urandom_range(0, 2) == 0 ? 0 : 4;
			stall_max = $urandom_range(0, 2) == 0 ? 0 : 4;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++)
				if (pushed < 600)
					push_frame(n, (f == frames - 1 && $urandom_range(0, 5) == 0) ?
						$urandom_range(0, n - 1) : n, $urandom_range(0, 2) == 0);
			settle();
		end

		if (pixel_q.size() != 0) report("pixels never delivered", 0, pixel_q.size());
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
